// ===== rtl/mrpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrpm_pkg: shared widths, codes and types of the masked region pixel mean
// Field widths of the stream words, configuration register indexes, select
// mode codes and the status bundle of the iterative divider.
// ----------------------------------------------------------------------------
package mrpm_pkg;

    // Field widths of the stream words
    localparam int PIX_W   = 16;
    localparam int ACC_W   = 40;
    localparam int CNT_W   = 25;
    localparam int MEAN_W  = 24;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_FIELD_W = ACC_W + CNT_W + MEAN_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_W    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_H    = 3'd5;

    // Pixel select modes
    localparam logic [1:0] MODE_ALL  = 2'd0;
    localparam logic [1:0] MODE_MASK = 2'd1;
    localparam logic [1:0] MODE_RECT = 2'd2;

    typedef logic [ACC_W-1:0]  acc_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [MEAN_W-1:0] mean_t;

    // Divider status seen by the frame controller
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage : mrpm_pkg
`default_nettype wire

// ===== rtl/mrpm_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrpm_divider: iterative restoring divider for the frame mean
// Produces one quotient bit per cycle with a single shared subtractor.
// The quotient saturates at the mean width; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module mrpm_divider #(
    parameter int DVD_W = 48
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire [DVD_W-1:0]      dividend,
    input  mrpm_pkg::cnt_t       divisor,
    output mrpm_pkg::div_status_t status,
    output mrpm_pkg::mean_t      quotient
);
    import mrpm_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  dvd_reg;
    cnt_t              dsr_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              zero_reg;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;
    logic [CNT_W-1:0]  rem_next;
    logic              q_ovf;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end

    // Sequence the quotient bits; quotient bits replace dividend bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            rem_reg  <= '0;
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    // Clamp to the mean width; empty selection reads as zero
    assign q_ovf    = |dvd_reg[DVD_W-1:MEAN_W];
    assign quotient = zero_reg ? '0 : (q_ovf ? '1 : dvd_reg[MEAN_W-1:0]);

    assign status.busy = busy_reg;
    assign status.done = done_reg;

    // Start only lands on an idle divider
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // Done follows the last step
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a finished run");

    // A run that starts keeps the unit busy next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not go busy after start");

endmodule : mrpm_divider
`default_nettype wire

// ===== rtl/masked_region_pixel_mean.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_region_pixel_mean: per-frame sum, count and mean of selected pixels
// Timing: a pixel word is accumulated in the cycle it is accepted; the result
//   word appears after the end-of-frame word once the iterative divider has
//   finished and the result register is free.
// Throughput: one pixel per cycle within a frame; input stalls after an
//   end-of-frame word while the divider runs, longer while the previous result waits.
// Reset: registers return to 640/0/0/0/1/1, counters clear, no result pending.
// ----------------------------------------------------------------------------
module masked_region_pixel_mean #(
    parameter int PIXEL_BITS = 16,
    parameter int MAX_DIM    = 4096,
    parameter int FRAC_BITS  = 8
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // Configuration write port
    input  wire                              cfg_wr_en,
    input  wire [mrpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [mrpm_pkg::CFG_W-1:0]        cfg_data,
    // Pixel stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [mrpm_pkg::IN_TDATA_W-1:0]   s_tdata,   // [15:0] pixel
    input  wire                              s_tuser,   // [0] roi_bit
    input  wire                              s_tlast,   // frame_end
    // Result stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [mrpm_pkg::OUT_TDATA_W-1:0] m_tdata    // [39:0] total_sum,
                                                        // [64:40] pixel_count,
                                                        // [88:65] mean_value
);
    import mrpm_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM);
    localparam int CW    = (DIM_W + 1 > 14) ? DIM_W + 1 : 14;
    localparam int DVD_W = ACC_W + FRAC_BITS;
    localparam logic [PIX_W-1:0] PIX_MASK =
        (PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((64'd1 << PIXEL_BITS) - 64'd1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    // Configuration registers
    logic [CFG_W-1:0] frame_width_reg;
    logic [1:0]       select_mode_reg;
    logic [POS_W-1:0] region_x_reg;
    logic [POS_W-1:0] region_y_reg;
    logic [CFG_W-1:0] region_w_reg;
    logic [CFG_W-1:0] region_h_reg;

    // Frame state
    logic             state_reg;
    logic [DIM_W-1:0] col_reg;
    logic [DIM_W-1:0] row_reg;
    acc_t             acc_reg;
    cnt_t             cnt_reg;
    logic [DIM_W-1:0] col_next;
    logic [DIM_W-1:0] row_next;
    acc_t             acc_next;
    cnt_t             cnt_next;

    // Totals of the frame under division
    acc_t             sum_div_reg;
    cnt_t             cnt_div_reg;

    // Result register
    logic             m_tvalid_reg;
    acc_t             sum_out_reg;
    cnt_t             cnt_out_reg;
    mean_t            mean_out_reg;

    logic             in_fire;
    logic [PIX_W-1:0] pix;
    logic [CW-1:0]    fw_eff;
    logic [CW-1:0]    col_inc;
    logic [CW-1:0]    x_end;
    logic [CW-1:0]    y_end;
    logic             in_rect;
    logic             take;
    logic [ACC_W:0]   acc_sum;
    acc_t             acc_upd;
    cnt_t             cnt_upd;
    logic             div_start;
    logic             out_load;
    div_status_t      div_status;
    mean_t            div_quot;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= CFG_W'(640);
            select_mode_reg <= MODE_ALL;
            region_x_reg    <= '0;
            region_y_reg    <= '0;
            region_w_reg    <= CFG_W'(1);
            region_h_reg    <= CFG_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH: frame_width_reg <= cfg_data;
                REG_SELECT_MODE: select_mode_reg <= cfg_data[1:0];
                REG_REGION_X:    region_x_reg    <= cfg_data[POS_W-1:0];
                REG_REGION_Y:    region_y_reg    <= cfg_data[POS_W-1:0];
                REG_REGION_W:    region_w_reg    <= cfg_data;
                REG_REGION_H:    region_h_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign div_start = in_fire && s_tlast;
    assign pix       = s_tdata & PIX_MASK;

    // Move the finished mean into the result register once it is free
    assign out_load  = (state_reg == S_DIV) && !div_status.busy &&
                       (!m_tvalid_reg || m_tready);

    // Clamp the frame width and find the column wrap
    always_comb
    begin
        fw_eff = CW'(frame_width_reg);
        if (fw_eff == '0)
            fw_eff = CW'(1);
        else if (fw_eff > CW'(MAX_DIM))
            fw_eff = CW'(MAX_DIM);
        col_inc = CW'(col_reg) + CW'(1);
    end

    // Select the pixel by mode
    always_comb
    begin
        x_end   = CW'(region_x_reg) + CW'(region_w_reg);
        y_end   = CW'(region_y_reg) + CW'(region_h_reg);
        in_rect = (CW'(col_reg) >= CW'(region_x_reg)) && (CW'(col_reg) < x_end) &&
                  (CW'(row_reg) >= CW'(region_y_reg)) && (CW'(row_reg) < y_end);
        case (select_mode_reg)
            MODE_ALL:  take = 1'b1;
            MODE_MASK: take = s_tuser;
            MODE_RECT: take = in_rect;
            default:   take = 1'b0;
        endcase
    end

    // Saturating accumulate and count
    always_comb
    begin
        acc_sum = {1'b0, acc_reg} + (ACC_W + 1)'(pix);
        acc_upd = acc_reg;
        cnt_upd = cnt_reg;
        if (take)
        begin
            acc_upd = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
            if (cnt_reg != '1)
                cnt_upd = cnt_reg + CNT_W'(1);
        end
    end

    // Advance position, or clear everything at the end of the frame
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (in_fire)
        begin
            if (s_tlast)
            begin
                col_next = '0;
                row_next = '0;
                acc_next = '0;
                cnt_next = '0;
            end
            else
            begin
                acc_next = acc_upd;
                cnt_next = cnt_upd;
                if (col_inc >= fw_eff)
                begin
                    col_next = '0;
                    if (row_reg < DIM_W'(MAX_DIM - 1))
                        row_next = row_reg + DIM_W'(1);
                end
                else
                begin
                    col_next = col_inc[DIM_W-1:0];
                end
            end
        end
    end

    // Frame state and sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (div_start)
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Stage the frame totals for the divider, then load the result fields
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            sum_div_reg <= acc_upd;
            cnt_div_reg <= cnt_upd;
        end
        if (out_load)
        begin
            sum_out_reg  <= sum_div_reg;
            cnt_out_reg  <= cnt_div_reg;
            mean_out_reg <= div_quot;
        end
    end

    mrpm_divider #(
        .DVD_W (DVD_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DVD_W'(acc_upd) << FRAC_BITS),
        .divisor  (cnt_upd),
        .status   (div_status),
        .quotient (div_quot)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, mean_out_reg, cnt_out_reg, sum_out_reg};

    // Frame state is clear after the end-of-frame word
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (acc_reg == '0 && cnt_reg == '0 && col_reg == '0 && row_reg == '0))
        else $error("frame state not cleared after end of frame");

    // No pixel enters while the divider runs
    a_no_input_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> !s_tready)
        else $error("input accepted during division");

    // A result word appears only after the divider finishes
    a_result_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DIV && !div_status.busy))
        else $error("result word without a finished division");

    // The divider finishes only inside a division
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_DIV))
        else $error("divider done outside a division");

    // An empty selection reports a zero mean
    a_zero_mean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && cnt_out_reg == '0) |-> (mean_out_reg == '0))
        else $error("nonzero mean for empty selection");

endmodule : masked_region_pixel_mean
`default_nettype wire

// ===== tb/frame_stats_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_stats_checker: predicts and checks the per-frame pixel statistics
// Watches the configuration port and both streams of the region pixel mean
// block. Keeps its own copy of the registers, the column/row position and the
// running sum and count. Each accepted end-of-frame word queues the expected
// sum, count and mean. Each accepted result word is compared field by field
// with the oldest queued frame.
// ----------------------------------------------------------------------------
module frame_stats_checker #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 8
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_wr_en,
    input  wire [mrpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [mrpm_pkg::CFG_W-1:0]        cfg_data,
    input  wire                              s_tvalid,
    input  wire                              s_tready,
    input  wire [mrpm_pkg::IN_TDATA_W-1:0]   s_tdata,   // [15:0] pixel
    input  wire                              s_tuser,   // [0] roi_bit
    input  wire                              s_tlast,   // frame_end
    input  wire                              m_tvalid,
    input  wire                              m_tready,
    input  wire [mrpm_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [39:0] total_sum,
                                                        // [64:40] pixel_count,
                                                        // [88:65] mean_value
    output int                               fail_count,
    output int                               pending
);
    import mrpm_pkg::*;

    localparam logic [63:0] MEAN_LIMIT = (64'd1 << MEAN_W) - 64'd1;

    typedef struct {
        acc_t  sum;
        cnt_t  count;
        mean_t mean;
    } frame_stats_t;

    // Shadow registers
    logic [CFG_W-1:0] frame_width = 13'd640;
    logic [1:0]       select_mode = MODE_ALL;
    logic [POS_W-1:0] region_x    = '0;
    logic [POS_W-1:0] region_y    = '0;
    logic [CFG_W-1:0] region_w    = 13'd1;
    logic [CFG_W-1:0] region_h    = 13'd1;

    // Frame position and running totals
    logic [POS_W-1:0] col       = '0;
    logic [POS_W-1:0] row       = '0;
    acc_t             pixel_sum = '0;
    cnt_t             pixel_cnt = '0;

    frame_stats_t     frame_stats_q[$];
    int               mismatches = 0;

    function automatic logic in_region();
        return int'(col) >= int'(region_x) &&
               int'(col) < int'(region_x) + int'(region_w) &&
               int'(row) >= int'(region_y) &&
               int'(row) < int'(region_y) + int'(region_h);
    endfunction

    task automatic clear_frame();
        col       = '0;
        row       = '0;
        pixel_sum = '0;
        pixel_cnt = '0;
    endtask

    // Fold one pixel into the running totals; close the frame on its last word
    task automatic predict_frame_stats(input logic [PIX_W-1:0] pix, input logic roi,
                                       input logic last);
        logic          selected;
        logic [ACC_W:0] wide_sum;
        logic [63:0]   scaled;
        int            eff_width;
        frame_stats_t  stats;
        case (select_mode)
            MODE_ALL:  selected = 1'b1;
            MODE_MASK: selected = roi;
            MODE_RECT: selected = in_region();
            default:   selected = 1'b0;
        endcase
        // Saturate both the sum and the count
        if (selected)
        begin
            wide_sum  = {1'b0, pixel_sum} + (ACC_W + 1)'(pix);
            pixel_sum = wide_sum[ACC_W] ? '1 : wide_sum[ACC_W-1:0];
            if (pixel_cnt != '1)
                pixel_cnt = pixel_cnt + CNT_W'(1);
        end
        if (last)
        begin
            stats.sum   = pixel_sum;
            stats.count = pixel_cnt;
            stats.mean  = '0;
            if (pixel_cnt != '0)
            begin
                scaled     = (64'(pixel_sum) << FRAC_BITS) / 64'(pixel_cnt);
                stats.mean = (scaled > MEAN_LIMIT) ? '1 : scaled[MEAN_W-1:0];
            end
            frame_stats_q.push_back(stats);
            clear_frame();
        end
        else
        begin
            // Wrap the column at the clamped width, hold the row at its top
            eff_width = (frame_width == '0) ? 1 :
                        (int'(frame_width) > MAX_DIM) ? MAX_DIM : int'(frame_width);
            if (int'(col) + 1 >= eff_width)
            begin
                col = '0;
                if (int'(row) < MAX_DIM - 1)
                    row = row + POS_W'(1);
            end
            else
                col = col + POS_W'(1);
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_stats_t stats;
        if (!rst_n)
        begin
            frame_width = 13'd640;
            select_mode = MODE_ALL;
            region_x    = '0;
            region_y    = '0;
            region_w    = 13'd1;
            region_h    = 13'd1;
            clear_frame();
            frame_stats_q.delete();
            pending    <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            // Pixel word uses the settings in force before this edge
            if (s_tvalid && s_tready)
                predict_frame_stats(s_tdata[PIX_W-1:0], s_tuser, s_tlast);

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH: frame_width = cfg_data;
                    REG_SELECT_MODE: select_mode = cfg_data[1:0];
                    REG_REGION_X:    region_x    = cfg_data[POS_W-1:0];
                    REG_REGION_Y:    region_y    = cfg_data[POS_W-1:0];
                    REG_REGION_W:    region_w    = cfg_data;
                    REG_REGION_H:    region_h    = cfg_data;
                    default: ;
                endcase
            end

            // Compare a result word with the oldest finished frame
            if (m_tvalid && m_tready)
            begin
                if (frame_stats_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result expected none actual %0d/%0d/%0d",
                             $time, m_tdata[0 +: ACC_W], m_tdata[ACC_W +: CNT_W],
                             m_tdata[ACC_W+CNT_W +: MEAN_W]);
                end
                else
                begin
                    stats = frame_stats_q.pop_front();
                    check_field("total_sum", 64'(stats.sum), 64'(m_tdata[0 +: ACC_W]));
                    check_field("pixel_count", 64'(stats.count),
                                64'(m_tdata[ACC_W +: CNT_W]));
                    check_field("mean_value", 64'(stats.mean),
                                64'(m_tdata[ACC_W+CNT_W +: MEAN_W]));
                end
            end

            pending    <= frame_stats_q.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== tb/masked_region_pixel_mean_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_region_pixel_mean_test: stimulus and verdict for the pixel mean block
// Drives frames of pixel words under a series of register settings: a short
// directed set for the extremes and corner cases, then random frames with
// random idle bursts on both streams.
// The frame_stats_checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module masked_region_pixel_mean_test;
    import mrpm_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_WORDS = 1500;

    // Codes the package leaves unnamed
    localparam logic [1:0]           MODE_NONE      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cur_width     = 640;

    masked_region_pixel_mean u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    frame_stats_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: ready with random stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 14);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one pixel word, maybe after an idle burst, and hold until taken
    task automatic send_word(input logic [PIX_W-1:0] pix, input logic roi,
                             input logic last);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= roi;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_frame(input int n_words);
        logic [PIX_W-1:0] pix;
        for (int i = 0; i < n_words; i++)
        begin
            case ($urandom_range(0, 9))
                0:       pix = '0;
                1:       pix = '1;
                default: pix = PIX_W'($urandom_range(0, 16'hFFFF));
            endcase
            send_word(pix, 1'($urandom_range(0, 1)), i == n_words - 1);
        end
    endtask

    // Stop sending and wait until every frame result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Quiesce the block, then load all six registers
    task automatic start_phase(input logic [CFG_W-1:0] fw, input logic [1:0] mode,
                               input logic [CFG_W-1:0] rx, input logic [CFG_W-1:0] ry,
                               input logic [CFG_W-1:0] rw, input logic [CFG_W-1:0] rh);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_SELECT_MODE, CFG_W'(mode));
        write_reg(REG_REGION_X, rx);
        write_reg(REG_REGION_Y, ry);
        write_reg(REG_REGION_W, rw);
        write_reg(REG_REGION_H, rh);
        cfg_wr_en <= 1'b0;
        cur_width = (fw == '0) ? 1 : (int'(fw) > 4096) ? 4096 : int'(fw);
    endtask

    // Mostly narrow frames and small rectangles, now and then out-of-range values
    task automatic random_phase();
        logic [CFG_W-1:0] fw;
        logic [CFG_W-1:0] rx;
        logic [CFG_W-1:0] ry;
        logic [CFG_W-1:0] rw;
        logic [CFG_W-1:0] rh;
        logic [1:0]       mode;
        int               span;
        case ($urandom_range(0, 9))
            0:       fw = '0;
            1:       fw = CFG_W'($urandom_range(4096, 8191));
            2:       fw = CFG_W'($urandom_range(17, 64));
            default: fw = CFG_W'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 9))
            0:       mode = MODE_NONE;
            1, 2:    mode = MODE_ALL;
            3, 4:    mode = MODE_MASK;
            default: mode = MODE_RECT;
        endcase
        span = (fw == '0) ? 1 : (int'(fw) > 40) ? 40 : int'(fw);
        rx = CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) :
                                                  $urandom_range(0, span + 1));
        rw = CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(4096, 8191) :
                                                  $urandom_range(0, span + 2));
        ry = CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) :
                                                  $urandom_range(0, 7));
        rh = CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(4096, 8191) :
                                                  $urandom_range(0, 8));
        start_phase(fw, mode, rx, ry, rw, rh);
    endtask

    initial
    begin
        int random_words;
        int n_words;
        random_words = 0;
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: whole frame, pixel extremes, one-pixel frame
        send_word(16'h0000, 1'b0, 1'b0);
        send_word(16'hFFFF, 1'b1, 1'b0);
        send_word(16'hFFFF, 1'b0, 1'b1);
        send_word(16'h0000, 1'b1, 1'b1);

        // Unused mode, zero frame width, writes to unused indexes
        start_phase('0, MODE_NONE, 13'h0FFF, 13'h0FFF, 13'h1FFF, 13'h1FFF);
        write_reg(REG_SPARE_LOW, 13'h1FFF);
        write_reg(REG_SPARE_HIGH, 13'h1FFF);
        cfg_wr_en <= 1'b0;
        send_word(16'h5A5A, 1'b1, 1'b0);
        send_word(16'hFFFF, 1'b1, 1'b1);

        // Rectangle clipped at the right and bottom edges
        start_phase(13'd4, MODE_RECT, 13'd2, 13'd1, 13'd8, 13'd8);
        send_frame(12);

        // Mask bit off and on, one-pixel frames
        start_phase(13'd4, MODE_MASK, '0, '0, 13'd1, 13'd1);
        send_word(16'hFFFF, 1'b0, 1'b1);
        send_word(16'hFFFF, 1'b1, 1'b1);

        // Zero-width rectangle, then a rectangle that starts at the last column
        start_phase(13'h1FFF, MODE_RECT, '0, '0, '0, 13'd5);
        send_frame(2);
        start_phase(13'h1FFF, MODE_RECT, 13'h0FFF, '0, 13'd4096, 13'd4096);
        send_frame(2);

        // Random frames under random settings; no idling near the end
        while (random_words < RANDOM_WORDS)
        begin
            if (random_words > RANDOM_WORDS * 7 / 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
                recv_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            end
            random_phase();
            repeat ($urandom_range(1, 5))
            begin
                if (cur_width <= 16 && $urandom_range(0, 3) != 0)
                    n_words = cur_width * $urandom_range(1, 6);
                else
                    n_words = $urandom_range(1, 40);
                send_frame(n_words);
                random_words += n_words;
                if (send_idle_pct != 0 && $urandom_range(0, 4) == 0)
                    wait_for_results();
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mrpm_pkg.sv
rtl/mrpm_divider.sv
rtl/masked_region_pixel_mean.sv
tb/frame_stats_checker.sv
tb/masked_region_pixel_mean_test.sv
